// File: hdl/ptd_pkg.sv
// ptd_pkg: shared types and constants for the presence timeout detector.
// No dependencies; imported by every module of the block.

package ptd_pkg;

    localparam int TS_W        = 32;
    localparam int CFG_IDX_W   = 2;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 8;

    // register indexes on the config port
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_TIMEOUT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STABILIZE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COOLDOWN     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BOOT_TIME    = 2'd3;

    localparam logic [TS_W-1:0] HOLD_TIMEOUT_RST = 32'd30000;
    localparam logic [TS_W-1:0] STABILIZE_RST    = 32'd5000;
    localparam logic [TS_W-1:0] COOLDOWN_RST     = 32'd300000;
    localparam logic [TS_W-1:0] BOOT_TIME_RST    = 32'd0;

    // event codes
    localparam logic [1:0] EV_NONE     = 2'd0;
    localparam logic [1:0] EV_RISING   = 2'd1;
    localparam logic [1:0] EV_TIMEDOUT = 2'd2;
    localparam logic [1:0] EV_CANCELED = 2'd3;

    typedef struct packed {
        logic [TS_W-1:0] hold_timeout_ms;
        logic [TS_W-1:0] settle_ms;
        logic [TS_W-1:0] alert_gap_ms;
        logic [TS_W-1:0] boot_time_ms;
    } cfg_t;

    typedef struct packed {
        logic            consume_latch;
        logic            level;
        logic [TS_W-1:0] now_ms;
    } poll_t;

    typedef struct packed {
        logic       latch_was_set;
        logic [1:0] event_res;
    } result_t;

endpackage

// File: hdl/ptd_cfg_regs.sv
// ptd_cfg_regs: configuration register file of the presence timeout detector.
// Depends on ptd_pkg.

module ptd_cfg_regs
    import ptd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [TS_W-1:0]       cfg_wdata,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_HOLD_TIMEOUT: cfg_next.hold_timeout_ms = cfg_wdata;
                REG_STABILIZE:    cfg_next.settle_ms       = cfg_wdata;
                REG_COOLDOWN:     cfg_next.alert_gap_ms    = cfg_wdata;
                REG_BOOT_TIME:    cfg_next.boot_time_ms    = cfg_wdata;
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.hold_timeout_ms <= HOLD_TIMEOUT_RST;
            cfg_reg.settle_ms       <= STABILIZE_RST;
            cfg_reg.alert_gap_ms    <= COOLDOWN_RST;
            cfg_reg.boot_time_ms    <= BOOT_TIME_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: hdl/ptd_eval.sv
// ptd_eval: detector state and the per-poll decision logic.
// Depends on ptd_pkg; state advances only on the update strobe.

module ptd_eval
    import ptd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  cfg_t    cfg,
    input  poll_t   item,
    input  logic    update,
    output result_t res
);

    logic            prev_level_reg, prev_level_next;
    logic            win_open_reg, win_open_next;
    logic [TS_W-1:0] win_start_reg, win_start_next;
    logic [TS_W-1:0] last_alert_reg, last_alert_next;
    logic            latched_reg, latched_next;

    logic [TS_W-1:0] since_boot;
    logic [TS_W-1:0] held;
    logic [TS_W-1:0] since_alert;
    logic            settling;
    logic            hold_ok;
    logic            cool_ok;
    logic            latch_after;
    logic [1:0]      ev;

    // all differences wrap modulo 2^32
    assign since_boot  = item.now_ms - cfg.boot_time_ms;
    assign held        = item.now_ms - win_start_reg;
    assign since_alert = item.now_ms - last_alert_reg;
    assign settling    = since_boot < cfg.settle_ms;
    assign hold_ok     = held >= cfg.hold_timeout_ms;
    // last alert of zero reads as never alerted
    assign cool_ok     = (last_alert_reg == '0) || (since_alert >= cfg.alert_gap_ms);

    always_comb
    begin
        prev_level_next = item.level;
        win_open_next   = win_open_reg;
        win_start_next  = win_start_reg;
        last_alert_next = last_alert_reg;
        latch_after     = latched_reg;
        ev              = EV_NONE;
        if (!settling)
        begin
            if (!prev_level_reg && item.level)
            begin
                win_open_next  = 1'b1;
                win_start_next = item.now_ms;
                ev             = EV_RISING;
            end
            else if (win_open_reg)
            begin
                if (item.level && hold_ok && cool_ok)
                begin
                    latch_after     = 1'b1;
                    last_alert_next = item.now_ms;
                    ev              = EV_TIMEDOUT;
                end
                else if (!item.level)
                begin
                    win_open_next = 1'b0;
                    ev            = EV_CANCELED;
                end
            end
        end
        latched_next      = latch_after & ~item.consume_latch;
        res.event_res     = ev;
        res.latch_was_set = latch_after & item.consume_latch;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_level_reg <= 1'b0;
            win_open_reg   <= 1'b0;
            win_start_reg  <= '0;
            last_alert_reg <= '0;
            latched_reg    <= 1'b0;
        end
        else if (update)
        begin
            prev_level_reg <= prev_level_next;
            win_open_reg   <= win_open_next;
            win_start_reg  <= win_start_next;
            last_alert_reg <= last_alert_next;
            latched_reg    <= latched_next;
        end
    end

endmodule

// File: hdl/presence_timeout_detector.sv
// presence_timeout_detector: top level, input register, evaluation, result register.
// Depends on ptd_pkg, ptd_cfg_regs and ptd_eval.
//
//   channel   direction  handshake          payload
//   s_*       in         s_tvalid/s_tready  s_tdata: now_ms, level, consume_latch
//   m_*       out        m_tvalid/m_tready  m_tdata: event_res, latch_was_set
//   cfg_*     in         cfg_we             cfg_index, cfg_wdata
//
// One poll per clock unless the output stalls; a poll passes input, then result register.
// The input register feeds the decision logic, which writes the result register
// and the detector state in the same edge.
// A stalled output holds its beat; the input register still takes one more beat.
// rst_n clears both valid flags and the detector state and reloads the config defaults.

module presence_timeout_detector
    import ptd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // [31:0] now_ms, [32] level, [33] consume_latch
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // [1:0] event_res, [2] latch_was_set
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [TS_W-1:0]        cfg_wdata
);

    cfg_t    cfg;
    poll_t   in_item_reg;
    logic    in_valid_reg, in_valid_next;
    result_t out_res_reg;
    result_t res;
    logic    out_valid_reg, out_valid_next;
    logic    move;
    logic    accept;

    ptd_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    ptd_eval u_eval (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .item   (in_item_reg),
        .update (move),
        .res    (res)
    );

    assign move     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || move;
    assign accept   = s_tvalid && s_tready;

    assign in_valid_next  = accept || (in_valid_reg && !move);
    assign out_valid_next = move || (out_valid_reg && !m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_item_reg <= s_tdata[TS_W+1:0];
        end
        if (move)
        begin
            out_res_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_TDATA_W-3){1'b0}}, out_res_reg};

endmodule

// File: hdl/ptd_checker.sv
// ptd_checker: port-level assertions for the presence timeout detector.
// Depends on ptd_pkg; bound to presence_timeout_detector at the end of this file.

module ptd_checker
    import ptd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [OUT_TDATA_W-1:0] m_tdata
);

    // no result beat is shown right after reset
    a_reset_empty: assert property (@(posedge clk) $rose(rst_n) |-> !m_tvalid)
        else $error("m_tvalid high right after reset");

    // a stalled result beat holds
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result beat changed");

    // with the output empty the input side can always take a beat
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("s_tready low while output is empty");

    // output is valid once an accepted poll clears the input and result registers
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |-> ##2 m_tvalid)
        else $error("accepted poll produced no result beat");

endmodule

bind presence_timeout_detector ptd_checker u_ptd_checker (.*);

// File: sim/testbench.sv
// testbench: self-checking bench for presence_timeout_detector.
// Needs ptd_pkg and the block's RTL; it keeps its own copy of the detector
// state, predicts each poll's event and latch readout, and checks every output beat.

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import ptd_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam logic [TS_W-1:0] TS_MAX = 32'hFFFF_FFFF;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [TS_W-1:0]        cfg_wdata = '0;

    // shadow of the detector
    cfg_t            cfg_shadow;
    logic            det_prev_level;
    logic            det_window_open;
    logic [TS_W-1:0] det_window_start;
    logic [TS_W-1:0] det_last_alert;
    logic            det_latched;

    result_t pending_results[$];
    int      err_count   = 0;
    int      cycle_count = 0;
    bit      gaps_on     = 1'b1;

    presence_timeout_detector DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // event and latch readout for one poll; advances the shadow state
    function automatic result_t detector_predict(poll_t p);
        logic [TS_W-1:0] since_boot;
        logic [TS_W-1:0] held;
        logic [TS_W-1:0] since_alert;
        result_t         r;
        since_boot  = p.now_ms - cfg_shadow.boot_time_ms;
        held        = p.now_ms - det_window_start;
        since_alert = p.now_ms - det_last_alert;
        r.event_res     = EV_NONE;
        r.latch_was_set = 1'b0;
        if (since_boot < cfg_shadow.settle_ms)
            r.event_res = EV_NONE;
        else if (!det_prev_level && p.level)
        begin
            det_window_open  = 1'b1;
            det_window_start = p.now_ms;
            r.event_res      = EV_RISING;
        end
        else if (det_window_open)
        begin
            // last_alert of zero reads as never alerted
            if (p.level && held >= cfg_shadow.hold_timeout_ms &&
                (det_last_alert == '0 || since_alert >= cfg_shadow.alert_gap_ms))
            begin
                det_latched    = 1'b1;
                det_last_alert = p.now_ms;
                r.event_res    = EV_TIMEDOUT;
            end
            else if (!p.level)
            begin
                det_window_open = 1'b0;
                r.event_res     = EV_CANCELED;
            end
        end
        det_prev_level = p.level;
        if (p.consume_latch)
        begin
            r.latch_was_set = det_latched;
            det_latched     = 1'b0;
        end
        return r;
    endfunction

    // output check first, then prediction of the beat accepted at this edge
    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got = m_tdata[2:0];
                if (pending_results.size() == 0)
                begin
                    $error("unexpected output beat %h", m_tdata);
                    err_count++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (got.event_res !== want.event_res)
                    begin
                        $error("event_res: expected %0d, got %0d",
                               want.event_res, got.event_res);
                        err_count++;
                    end
                    if (got.latch_was_set !== want.latch_was_set)
                    begin
                        $error("latch_was_set: expected %0d, got %0d",
                               want.latch_was_set, got.latch_was_set);
                        err_count++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                pending_results.push_back(detector_predict(s_tdata[$bits(poll_t)-1:0]));
        end
    end

    // receiver stalls in bursts, with runs of steady ready between them
    initial
    begin
        int n;
        forever
        begin
            if (gaps_on && $urandom_range(0, 2) == 0)
            begin
                m_tready <= 1'b0;
                n = $urandom_range(1, 11);
                repeat (n) @(posedge clk);
            end
            m_tready <= 1'b1;
            n = $urandom_range(1, 40);
            repeat (n) @(posedge clk);
        end
    end

    task automatic send_poll(logic [TS_W-1:0] now_ts, logic lvl, logic consume);
        poll_t p;
        int    n;
        if (gaps_on && $urandom_range(0, 5) == 0)
        begin
            s_tvalid <= 1'b0;
            n = $urandom_range(1, 11);
            repeat (n) @(posedge clk);
        end
        p.now_ms        = now_ts;
        p.level         = lvl;
        p.consume_latch = consume;
        s_tvalid <= 1'b1;
        s_tdata  <= IN_TDATA_W'(p);
        do @(posedge clk); while (!s_tready);
    endtask

    // drop valid and let every expected beat drain before touching registers
    task automatic drain;
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // drives one register write, then drops the enable and idles before returning
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [TS_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            REG_HOLD_TIMEOUT: cfg_shadow.hold_timeout_ms = val;
            REG_STABILIZE:    cfg_shadow.settle_ms       = val;
            REG_COOLDOWN:     cfg_shadow.alert_gap_ms    = val;
            REG_BOOT_TIME:    cfg_shadow.boot_time_ms    = val;
            default: ;
        endcase
        @(posedge clk);
    endtask

    // reset values: settling, rising, alert, cooldown, re-alert, cancel, latch readout
    task automatic test_default_alert_flow;
        send_poll(32'd100,    1'b1, 1'b0);
        send_poll(32'd4999,   1'b0, 1'b1);
        send_poll(32'd5000,   1'b1, 1'b0);
        send_poll(32'd20000,  1'b1, 1'b0);
        send_poll(32'd35000,  1'b1, 1'b1);   // alert and readout in one poll
        send_poll(32'd40000,  1'b1, 1'b1);   // held long enough, still cooling down
        send_poll(32'd400000, 1'b1, 1'b0);
        send_poll(32'd400001, 1'b0, 1'b0);
        send_poll(32'd400002, 1'b0, 1'b1);
        drain();
    endtask

    // an alert stamped at time zero must not arm the cooldown
    task automatic test_alert_at_zero;
        write_reg(REG_HOLD_TIMEOUT, '0);
        write_reg(REG_STABILIZE, '0);
        write_reg(REG_COOLDOWN, '0);
        send_poll(32'hFFFF_FFF0, 1'b0, 1'b0);
        send_poll(32'hFFFF_FFF8, 1'b1, 1'b0);
        send_poll(32'd0,         1'b1, 1'b0);
        drain();
        write_reg(REG_COOLDOWN, TS_MAX);
        send_poll(32'd7, 1'b1, 1'b1);
        send_poll(32'd8, 1'b1, 1'b0);
        send_poll(32'd9, 1'b0, 1'b0);
        drain();
    endtask

    // settling window across the timestamp wrap, maximum hold and settle times
    task automatic test_settling_wrap;
        write_reg(REG_BOOT_TIME, 32'hFFFF_FF00);
        write_reg(REG_STABILIZE, 32'h200);
        write_reg(REG_HOLD_TIMEOUT, TS_MAX);
        write_reg(REG_COOLDOWN, '0);
        send_poll(32'h50,  1'b1, 1'b0);
        send_poll(32'h100, 1'b0, 1'b0);
        send_poll(32'h101, 1'b1, 1'b0);
        send_poll(32'h100, 1'b1, 1'b0);      // one ms back: held wraps to the max
        drain();
        write_reg(REG_STABILIZE, TS_MAX);
        send_poll(32'hFFFF_FEFE, 1'b1, 1'b1);
        send_poll(32'hFFFF_FEFF, 1'b0, 1'b0);
        drain();
    endtask

    function automatic logic [TS_W-1:0] pick_setting(int unsigned span);
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '0;
        else if (r == 1)
            return TS_MAX;
        return $urandom_range(0, span);
    endfunction

    // mostly time-ordered polls with level runs, plus some random-timestamp noise
    task automatic test_random_polls(int phases, int polls);
        int unsigned     scale;
        logic [TS_W-1:0] now_ts;
        logic            lvl;
        for (int ph = 0; ph < phases; ph++)
        begin
            scale = $urandom_range(1, 2000);
            write_reg(REG_HOLD_TIMEOUT, pick_setting(scale));
            write_reg(REG_STABILIZE, pick_setting(scale));
            write_reg(REG_COOLDOWN, pick_setting(4 * scale));
            write_reg(REG_BOOT_TIME, $urandom);
            now_ts = cfg_shadow.boot_time_ms + $urandom_range(0, 2 * scale);
            lvl    = 1'($urandom_range(0, 1));
            for (int i = 0; i < polls; i++)
            begin
                if ($urandom_range(0, 19) == 0)
                begin
                    now_ts = $urandom;
                    lvl    = 1'($urandom_range(0, 1));
                end
                else
                begin
                    now_ts = now_ts + $urandom_range(0, scale);
                    if ($urandom_range(0, 5) == 0)
                        lvl = ~lvl;
                end
                send_poll(now_ts, lvl, $urandom_range(0, 3) == 0);
            end
            drain();
        end
    endtask

    task automatic test_no_idle_tail;
        gaps_on = 1'b0;
        test_random_polls(1, 50);
    endtask

    initial
    begin
        cfg_shadow.hold_timeout_ms = HOLD_TIMEOUT_RST;
        cfg_shadow.settle_ms       = STABILIZE_RST;
        cfg_shadow.alert_gap_ms    = COOLDOWN_RST;
        cfg_shadow.boot_time_ms    = BOOT_TIME_RST;
        det_prev_level   = 1'b0;
        det_window_open  = 1'b0;
        det_window_start = '0;
        det_last_alert   = '0;
        det_latched      = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_default_alert_flow();
        test_alert_at_zero();
        test_settling_wrap();
        test_random_polls(8, 50);
        test_no_idle_tail();

        if (err_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
